>>> design/least_loaded_handle_dispatcher_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the least-loaded handle dispatcher.
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_HANDLE_DISPATCHER_CORE_MACROS_SVH
`define LEAST_LOADED_HANDLE_DISPATCHER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg
// Sizes, operation and status codes and controller states of the handle dispatcher.
// ----------------------------------------------------------------------------
package lld_pkg;

    localparam int HANDLE_SLOTS = 1024;
    localparam int MAX_WORKERS  = 16;

    localparam int HANDLE_W = 10;
    localparam int ADDR_W   = $clog2(HANDLE_SLOTS);
    localparam int WORKER_W = 4;
    localparam int LOAD_W   = 11;
    localparam int CFG_W    = 5;
    localparam int ENTRY_W  = WORKER_W + 1;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    // Operation codes carried on the func field.
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_MOVED   = 2'd1,
        ST_REMOVED = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PICK,
        S_DONE
    } t_state;

endpackage

>>> design/lld_ram.sv
// ----------------------------------------------------------------------------
// lld_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/least_loaded_handle_dispatcher_core.sv
// Flow: a remove item passes through S_READ and S_DONE, an add item through S_READ,
// S_PICK and S_DONE. Items are handled one at a time, since the handle table read,
// the load update and the least-loaded pick are done one after another.
// Reset: synchronous, active low; afterwards a clearing pass over all 1024 slots sweeps
// the handle table, during which no item is accepted (configuration writes still are).
// ----------------------------------------------------------------------------
// least_loaded_handle_dispatcher_core
// Assigns handles to the least-loaded active worker and releases them again.
// ----------------------------------------------------------------------------
`include "least_loaded_handle_dispatcher_core_macros.svh"

module least_loaded_handle_dispatcher_core import lld_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: number of active workers.
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // Request channel.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [HANDLE_W-1:0] i_handle,
    // Result channel.
    output logic                o_valid,
    input  logic                i_ready,
    output logic [WORKER_W-1:0] o_worker_index,
    output logic [1:0]          o_status
);

    localparam int LVL = $clog2(MAX_WORKERS);
    localparam int NL  = 2 ** LVL;

    // The handle table holds one entry per slot: a present bit above the worker index.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_func;
    logic                r_hit, n_hit;
    logic [WORKER_W-1:0] r_res_w, n_res_w;
    t_status             r_res_st, n_res_st;
    logic [LOAD_W-1:0]   r_load [MAX_WORKERS];
    logic [LOAD_W-1:0]   n_load [MAX_WORKERS];
    logic [CFG_W-1:0]    r_wcount;
    logic                r_out_valid, n_out_valid;
    logic [WORKER_W-1:0] r_out_w, n_out_w;
    t_status             r_out_st, n_out_st;

    logic                in_accept;
    logic                rd_present;
    logic [WORKER_W-1:0] rd_worker;
    logic [CFG_W-1:0]    w_active;
    logic [WORKER_W-1:0] w_pick;
    logic                out_free;

    // Comparison tree over the load counts. Node k has children 2k and 2k+1; the leaves
    // sit at NL + i. An inactive worker gets a key with its top bit set so it never wins.
    logic [LOAD_W:0]     heap_key [2*NL];
    logic [WORKER_W-1:0] heap_idx [2*NL];

    assign o_ready    = (r_state == S_IDLE);
    assign in_accept  = i_valid && o_ready;
    assign rd_present = ram_rdata[WORKER_W];
    assign rd_worker  = ram_rdata[WORKER_W-1:0];
    assign out_free   = !r_out_valid || i_ready;

    // The table is read at the incoming handle every cycle; the word captured at the
    // accepting edge is the one the controller works with. Handles wrap on the slot count.
    assign ram_raddr = i_handle[ADDR_W-1:0];

    lld_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(HANDLE_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // A worker count of zero means one worker, and anything above the maximum saturates.
    always_comb begin
        if (r_wcount == '0) begin
            w_active = CFG_W'(1);
        end else if (r_wcount > CFG_W'(MAX_WORKERS)) begin
            w_active = CFG_W'(MAX_WORKERS);
        end else begin
            w_active = r_wcount;
        end
    end

    // Ties go to the left child, which keeps the lowest index among equal loads.
    always_comb begin
        heap_key[0] = '0;
        heap_idx[0] = '0;
        for (int i = 0; i < NL; i++) begin
            heap_idx[NL+i] = WORKER_W'(i);
            if (i < MAX_WORKERS && CFG_W'(i) < w_active) begin
                heap_key[NL+i] = {1'b0, r_load[i % MAX_WORKERS]};
            end else begin
                heap_key[NL+i] = '1;
            end
        end
        for (int k = NL - 1; k >= 1; k--) begin
            if (heap_key[2*k+1] < heap_key[2*k]) begin
                heap_key[k] = heap_key[2*k+1];
                heap_idx[k] = heap_idx[2*k+1];
            end else begin
                heap_key[k] = heap_key[2*k];
                heap_idx[k] = heap_idx[2*k];
            end
        end
    end

    assign w_pick = heap_idx[1];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(HANDLE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_func == FUNC_REMOVE) ? S_DONE : S_PICK;
            end
            S_PICK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Datapath and outputs of each state.
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        n_clr_addr  = r_clr_addr;
        n_hit       = r_hit;
        n_res_w     = r_res_w;
        n_res_st    = r_res_st;
        n_load      = r_load;
        n_out_valid = r_out_valid && !i_ready;
        n_out_w     = r_out_w;
        n_out_st    = r_out_st;
        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            S_IDLE: begin
            end
            S_READ: begin
                // A present handle first gives back its place at its old worker,
                // both on remove and on a re-add.
                n_hit = rd_present;
                if (rd_present) begin
                    for (int i = 0; i < MAX_WORKERS; i++) begin
                        if (WORKER_W'(i) == rd_worker && r_load[i] != '0) begin
                            n_load[i] = r_load[i] - LOAD_W'(1);
                        end
                    end
                end
                if (r_func == FUNC_REMOVE) begin
                    if (rd_present) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, rd_worker};
                        n_res_w   = rd_worker;
                        n_res_st  = ST_REMOVED;
                    end else begin
                        n_res_w  = '0;
                        n_res_st = ST_MISSING;
                    end
                end
            end
            S_PICK: begin
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    if (WORKER_W'(i) == w_pick && r_load[i] != LOAD_MAX) begin
                        n_load[i] = r_load[i] + LOAD_W'(1);
                    end
                end
                ram_we    = 1'b1;
                ram_wdata = {1'b1, w_pick};
                n_res_w   = w_pick;
                n_res_st  = r_hit ? ST_MOVED : ST_ADDED;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_w     = r_res_w;
                    n_out_st    = r_res_st;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wcount    <= CFG_W'(1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_WORKERS; i++) begin
                r_load[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_load      <= n_load;
            if (i_cfg_we) begin
                r_wcount <= i_cfg_wdata;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= i_func;
            r_addr <= i_handle[ADDR_W-1:0];
        end
        r_hit    <= n_hit;
        r_res_w  <= n_res_w;
        r_res_st <= n_res_st;
        r_out_w  <= n_out_w;
        r_out_st <= n_out_st;
    end

    assign o_valid        = r_out_valid;
    assign o_worker_index = r_out_w;
    assign o_status       = r_out_st;

    `LLD_ASSERT_NEXT(a_accept_reads, in_accept, r_state == S_READ,
        "accepted item did not start a table read")
    `LLD_ASSERT_SAME(a_idle_no_write, r_state == S_IDLE, !ram_we,
        "table written while idle")
    `LLD_ASSERT_SAME(a_pick_active, r_state == S_PICK, CFG_W'(w_pick) < w_active,
        "picked an inactive worker")
    `LLD_ASSERT_SAME(a_miss_worker_zero, o_valid && o_status == ST_MISSING,
        o_worker_index == '0, "not-found result carries a worker")
    `LLD_ASSERT_SAME(a_result_from_done, $rose(r_out_valid), $past(r_state == S_DONE),
        "result appeared outside the done state")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for least_loaded_handle_dispatcher_core
// Drives add and remove requests under several worker-count settings, keeps
// its own model of the handle table and the worker loads, and checks every
// result item in order against the model.
// ----------------------------------------------------------------------------
module testbench import lld_pkg::*; ();

    // Cycles without any item moved on either channel before the run is
    // declared hung; the clearing pass over all 1024 slots counts toward them.
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 205;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] handle;
    } t_request;

    typedef struct packed {
        logic [WORKER_W-1:0] worker;
        t_status             status;
    } t_dispatch_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata    = '0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic                i_func         = 1'b0;
    logic [HANDLE_W-1:0] i_handle       = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [WORKER_W-1:0] o_worker_index;
    logic [1:0]          o_status;

    least_loaded_handle_dispatcher_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_handle       (i_handle),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_worker_index (o_worker_index),
        .o_status       (o_status)
    );

    // The clock runs with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Requests waiting to be presented, and the results they are known to cause.
    t_request         request_q[$];
    t_dispatch_result results_awaited[$];

    // Shadow copy of the dispatcher state. The owner of a handle is only read
    // while the handle is present, as in the block.
    logic                handle_present [HANDLE_SLOTS];
    logic [WORKER_W-1:0] handle_owner   [HANDLE_SLOTS];
    logic [LOAD_W-1:0]   worker_load_sh [MAX_WORKERS];
    logic [CFG_W-1:0]    worker_count_cfg = 5'd1;

    int send_idle_pct = 29;
    int recv_idle_pct = 64;
    int queued_count  = 0;
    int checked_count = 0;
    int fail_count    = 0;
    int settings_seen = 1;
    int stall_cycles  = 0;
    int status_seen [4] = '{default: 0};

    initial begin
        for (int i = 0; i < HANDLE_SLOTS; i++) begin
            handle_present[i] = 1'b0;
            handle_owner[i]   = '0;
        end
        for (int w = 0; w < MAX_WORKERS; w++) begin
            worker_load_sh[w] = '0;
        end
    end

    // Applies one request to the shadow state and returns the result it causes.
    // An add on a present handle first releases its old worker, then picks the
    // least loaded active worker exactly as for a new handle.
    function automatic t_dispatch_result dispatch_step(input logic func,
                                                       input logic [HANDLE_W-1:0] handle);
        t_dispatch_result res;
        int active;
        int best;
        active = (worker_count_cfg == 0) ? 1 :
                 (worker_count_cfg > MAX_WORKERS) ? MAX_WORKERS : int'(worker_count_cfg);
        if (func == FUNC_ADD) begin
            res.status = ST_ADDED;
            if (handle_present[handle]) begin
                if (worker_load_sh[handle_owner[handle]] != 0) begin
                    worker_load_sh[handle_owner[handle]]--;
                end
                res.status = ST_MOVED;
            end
            best = 0;
            for (int w = 1; w < active; w++) begin
                if (worker_load_sh[w] < worker_load_sh[best]) begin
                    best = w;
                end
            end
            res.worker             = WORKER_W'(best);
            handle_present[handle] = 1'b1;
            handle_owner[handle]   = WORKER_W'(best);
            if (worker_load_sh[best] != LOAD_MAX) begin
                worker_load_sh[best]++;
            end
        end else if (handle_present[handle]) begin
            // The owner may lie outside the active set after a worker-count
            // change; its load is still released.
            res.worker = handle_owner[handle];
            if (worker_load_sh[res.worker] != 0) begin
                worker_load_sh[res.worker]--;
            end
            handle_present[handle] = 1'b0;
            res.status             = ST_REMOVED;
        end else begin
            res.worker = '0;
            res.status = ST_MISSING;
        end
        status_seen[res.status]++;
        return res;
    endfunction

    // Driver: presents queued requests, idling at random while the channel is
    // free. A presented item is held until the block accepts it, and the
    // expected result is worked out at the edge of acceptance.
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                results_awaited.insert(results_awaited.size(),
                                       dispatch_step(i_func, i_handle));
            end
            if (!i_valid || o_ready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = request_q.pop_front();
                    i_valid  <= 1'b1;
                    i_func   <= req.func;
                    i_handle <= req.handle;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the result channel at random and compares each result
    // item with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_dispatch_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (results_awaited.size() == 0) begin
                    $error("result with no request outstanding: worker_index %0d status %0d",
                           o_worker_index, o_status);
                    fail_count++;
                end else begin
                    want = results_awaited.pop_front();
                    if (o_worker_index !== want.worker) begin
                        $error("worker_index mismatch: expected %0d, actual %0d",
                               want.worker, o_worker_index);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        fail_count++;
                    end
                    checked_count++;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("least_loaded_handle_dispatcher_core test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_request(input logic func, input int handle);
        t_request req;
        req.func   = func;
        req.handle = HANDLE_W'(handle);
        request_q.insert(request_q.size(), req);
        queued_count++;
    endtask

    // Every request causes exactly one result, so the block is idle once the
    // number of checked results reaches the number of queued requests.
    task automatic wait_until_drained();
        do @(posedge i_clk);
        while (checked_count != queued_count);
    endtask

    // Only called while the block is idle.
    task automatic write_worker_count(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        worker_count_cfg  = value;
        settings_seen++;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_cfg [RANDOM_PHASES];
        int               sel;
        int               handle;
        logic             func;

        phase_cfg = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd0, 5'd12};
        phase_cfg[7] = CFG_W'($urandom_range(0, 31));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of one worker: new add, re-add onto the same worker,
        // removes of present and absent handles, both handle extremes.
        queue_request(FUNC_ADD, 0);
        queue_request(FUNC_ADD, 1023);
        queue_request(FUNC_ADD, 0);
        queue_request(FUNC_REMOVE, 1023);
        queue_request(FUNC_REMOVE, 1023);
        queue_request(FUNC_REMOVE, 0);
        wait_until_drained();

        // All sixteen workers: spread, then a re-add that moves a handle to
        // the least loaded worker, then a remove of an absent handle.
        write_worker_count(5'd16);
        for (int h = 1; h <= 4; h++) begin
            queue_request(FUNC_ADD, h);
        end
        queue_request(FUNC_ADD, 2);
        queue_request(FUNC_REMOVE, 512);
        wait_until_drained();

        // A count of zero behaves as one worker. The remove then releases a
        // worker that is no longer active.
        write_worker_count(5'd0);
        queue_request(FUNC_ADD, 5);
        queue_request(FUNC_REMOVE, 3);
        wait_until_drained();

        // A count above the worker total saturates to sixteen.
        write_worker_count(5'd31);
        queue_request(FUNC_ADD, 6);
        queue_request(FUNC_ADD, 7);
        wait_until_drained();

        // Shrink the active set while handles stay in the table.
        write_worker_count(5'd2);
        queue_request(FUNC_REMOVE, 4);
        queue_request(FUNC_ADD, 8);
        queue_request(FUNC_REMOVE, 1);
        queue_request(FUNC_REMOVE, 8);
        wait_until_drained();

        // Random part. Most handles come from two small pools at the ends of
        // the range, so that re-adds and removes of present handles are
        // frequent; the rest are spread over the whole range.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES / 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 29;
            end else if (p == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_worker_count(phase_cfg[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    handle = $urandom_range(0, 63);
                end else if (sel < 75) begin
                    handle = $urandom_range(960, 1023);
                end else begin
                    handle = $urandom_range(0, 1023);
                end
                func = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_REMOVE;
                queue_request(func, handle);
            end
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results_awaited.size() != 0) begin
            $error("%0d expected results never arrived", results_awaited.size());
            fail_count++;
        end

        $display("Checked %0d results over %0d worker-count settings.",
                 checked_count, settings_seen);
        $display("Outcomes: %0d new adds, %0d moves, %0d removes, %0d not found.",
                 status_seen[ST_ADDED], status_seen[ST_MOVED],
                 status_seen[ST_REMOVED], status_seen[ST_MISSING]);
        if (fail_count == 0) begin
            $display("least_loaded_handle_dispatcher_core test passed");
        end else begin
            $display("least_loaded_handle_dispatcher_core test failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/lld_pkg.sv
design/lld_ram.sv
design/least_loaded_handle_dispatcher_core.sv
verif/testbench.sv
